### rtl/core/ttu_pkg.sv
// Shared constants, codes and entry types of the MAC translation table.
`timescale 1ns / 1ps
package ttu_pkg;

   localparam int LOCAL_ENTRIES  = 64;
   localparam int GLOBAL_ENTRIES = 128;
   localparam int LIDX_W  = $clog2(LOCAL_ENTRIES);
   localparam int GIDX_W  = $clog2(GLOBAL_ENTRIES);
   localparam int SCAN_W  = (LIDX_W > GIDX_W) ? LIDX_W : GIDX_W;
   localparam int LCNT_W  = $clog2(LOCAL_ENTRIES + 1);
   localparam int MAC_W   = 48;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [6:0]  LIST_MAX        = 7'd64;
   localparam logic [6:0]  RST_MAX_LOCAL   = 7'd64;
   localparam logic [31:0] RST_TIMEOUT     = 32'd3600;
   localparam logic [15:0] RST_PERIOD      = 16'd10;

   localparam logic [2:0] OP_LEARN    = 3'd0;
   localparam logic [2:0] OP_ANNOUNCE = 3'd1;
   localparam logic [2:0] OP_WITHDRAW = 3'd2;
   localparam logic [2:0] OP_LOOKUP   = 3'd3;
   localparam logic [2:0] OP_TICK     = 3'd4;
   localparam logic [2:0] OP_LIST     = 3'd5;

   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_NEW       = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   localparam logic [1:0] CSR_OWN_MAC   = 2'd0;
   localparam logic [1:0] CSR_MAX_LOCAL = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd2;
   localparam logic [1:0] CSR_PERIOD    = 2'd3;

   typedef struct packed {
      logic             used;
      logic             keep;
      logic [31:0]      seen;
      logic [MAC_W-1:0] addr;
   } local_entry_type;

   typedef struct packed {
      logic             used;
      logic [7:0]       orig;
      logic [MAC_W-1:0] addr;
   } remote_entry_type;

endpackage

### rtl/core/ttu_if.sv
// Request and response channel interfaces of the MAC translation table.
`timescale 1ns / 1ps
interface ttu_req_if;
   import ttu_pkg::*;
   logic             valid;
   logic             ready;
   logic [2:0]       opcode;
   logic [MAC_W-1:0] mac;
   logic [7:0]       orig_id;
   logic [6:0]       read_limit;
   modport source (output valid, opcode, mac, orig_id, read_limit, input ready);
   modport sink   (input valid, opcode, mac, orig_id, read_limit, output ready);
endinterface

interface ttu_rsp_if;
   import ttu_pkg::*;
   logic             valid;
   logic             ready;
   logic [2:0]       status;
   logic [7:0]       found_orig;
   logic [MAC_W-1:0] entry_mac;
   logic             changed_flag;
   logic             last;
   modport source (output valid, status, found_orig, entry_mac, changed_flag, last,
                   input ready);
   modport sink   (input valid, status, found_orig, entry_mac, changed_flag, last,
                   output ready);
endinterface

### rtl/core/ttu_local_cell.sv
// One local table slot in the rotating ring of local entries.
`timescale 1ns / 1ps
module ttu_local_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift,
   input  ttu_pkg::local_entry_type d,
   output ttu_pkg::local_entry_type q
);
   import ttu_pkg::*;

   logic             used_ff;
   logic             keep_ff;
   logic [31:0]      seen_ff;
   logic [MAC_W-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (shift) begin
         used_ff <= d.used;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         keep_ff <= d.keep;
         seen_ff <= d.seen;
         addr_ff <= d.addr;
      end
   end

   assign q = '{used: used_ff, keep: keep_ff, seen: seen_ff, addr: addr_ff};

endmodule

### rtl/core/ttu_remote_cell.sv
// One global table slot in the rotating ring of remote entries.
`timescale 1ns / 1ps
module ttu_remote_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift,
   input  ttu_pkg::remote_entry_type d,
   output ttu_pkg::remote_entry_type q
);
   import ttu_pkg::*;

   logic             used_ff;
   logic [7:0]       orig_ff;
   logic [MAC_W-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (shift) begin
         used_ff <= d.used;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         orig_ff <= d.orig;
         addr_ff <= d.addr;
      end
   end

   assign q = '{used: used_ff, orig: orig_ff, addr: addr_ff};

endmodule

### rtl/core/mac_translation_table_unit.sv
// MAC translation table: two rings of entry cells walked by one control unit.
// One item at a time. A scan rotates a ring once, one slot per cycle unless a list stalls.
// Lookup and withdraw scan the global ring. Learn scans the local ring; a new MAC takes a
// free local slot and leaves the global ring. Announce scans the global ring, fills a free
// slot when new, evicts the MAC locally. Tick may purge. One output register holds results.
// Synchronous reset clears control state and all used bits at once; no clearing pass.
`timescale 1ns / 1ps
module mac_translation_table_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   ttu_req_if.sink                              req_chan,
   ttu_rsp_if.source                            rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ttu_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [ttu_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [ttu_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import ttu_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_LFIND  = 11'b00000000010,
      S_LAPPLY = 11'b00000000100,
      S_REVICT = 11'b00000001000,
      S_RFIND  = 11'b00000010000,
      S_RAPPLY = 11'b00000100000,
      S_LEVICT = 11'b00001000000,
      S_LPURGE = 11'b00010000000,
      S_RWDRAW = 11'b00100000000,
      S_LLIST  = 11'b01000000000,
      S_DONE   = 11'b10000000000
   } state_type;

   // configuration
   logic [MAC_W-1:0] own_mac_ff;
   logic [6:0]       max_local_ff;
   logic [31:0]      timeout_ff;
   logic [15:0]      period_ff;
   logic             csr_write;
   logic [1:0]       csr_index;

   // control and table state
   state_type        state_ff, state_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic [SCAN_W-1:0] fidx_ff, fidx_in;
   logic             found_ff, found_in;
   logic             free_ff, free_in;
   logic [2:0]       op_ff, op_in;
   logic [MAC_W-1:0] mac_ff, mac_in;
   logic [7:0]       orig_ff, orig_in;
   logic [2:0]       st_ff, st_in;
   logic [7:0]       hit_orig_ff, hit_orig_in;
   logic [LCNT_W-1:0] n_ff, n_in;
   logic [LCNT_W-1:0] emit_ff, emit_in;
   logic [LCNT_W-1:0] count_ff, count_in;
   logic             changed_ff, changed_in;
   logic [31:0]      now_ff, now_in;
   logic [15:0]      cd_ff, cd_in;

   // output register
   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_orig_ff, rsp_orig_in;
   logic [MAC_W-1:0] rsp_mac_ff, rsp_mac_in;
   logic             rsp_changed_ff, rsp_changed_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_load;

   // rings
   local_entry_type  lq [LOCAL_ENTRIES];
   local_entry_type  ld [LOCAL_ENTRIES];
   remote_entry_type rq [GLOBAL_ENTRIES];
   remote_entry_type rd [GLOBAL_ENTRIES];
   local_entry_type  lh, lnew;
   remote_entry_type rh, rnew;
   logic             lshift, rshift, lscan, rscan;
   logic             l_last, r_last, l_hit, r_hit;

   logic             accept, can_emit, list_emit, aged;
   logic [6:0]       cap, lim, cnt7, n7;
   logic [31:0]      age_d;
   logic [15:0]      cd_load, cd_next;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-2];

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff   <= '0;
         max_local_ff <= RST_MAX_LOCAL;
         timeout_ff   <= RST_TIMEOUT;
         period_ff    <= RST_PERIOD;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_OWN_MAC:   own_mac_ff   <= csr_pwdata[MAC_W-1:0];
            CSR_MAX_LOCAL: max_local_ff <= csr_pwdata[6:0];
            CSR_TIMEOUT:   timeout_ff   <= csr_pwdata[31:0];
            CSR_PERIOD:    period_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_OWN_MAC:   csr_prdata = CSR_DATA_W'(own_mac_ff);
         CSR_MAX_LOCAL: csr_prdata = CSR_DATA_W'(max_local_ff);
         CSR_TIMEOUT:   csr_prdata = CSR_DATA_W'(timeout_ff);
         CSR_PERIOD:    csr_prdata = CSR_DATA_W'(period_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------- rings of cells ----------------
   for (genvar i = 0; i < LOCAL_ENTRIES; i++) begin : g_local
      ttu_local_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (lshift),
         .d     (ld[i]),
         .q     (lq[i])
      );
      if (i == LOCAL_ENTRIES - 1) begin : g_tail
         assign ld[i] = lnew;
      end else begin : g_link
         assign ld[i] = lq[i+1];
      end
   end

   for (genvar i = 0; i < GLOBAL_ENTRIES; i++) begin : g_remote
      ttu_remote_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (rshift),
         .d     (rd[i]),
         .q     (rq[i])
      );
      if (i == GLOBAL_ENTRIES - 1) begin : g_tail
         assign rd[i] = rnew;
      end else begin : g_link
         assign rd[i] = rq[i+1];
      end
   end

   // ---------------- head logic ----------------
   assign lh = lq[0];
   assign rh = rq[0];
   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign can_emit = !rsp_valid_ff || rsp_chan.ready;

   assign lscan = (state_ff == S_LFIND) || (state_ff == S_LAPPLY) || (state_ff == S_LEVICT) ||
                  (state_ff == S_LPURGE) || (state_ff == S_LLIST);
   assign rscan = (state_ff == S_RFIND) || (state_ff == S_RAPPLY) || (state_ff == S_REVICT) ||
                  (state_ff == S_RWDRAW);
   assign list_emit = (state_ff == S_LLIST) && lh.used && (emit_ff != n_ff);
   // hold the ring while a list entry waits for the output register
   assign lshift = lscan && (!list_emit || can_emit);
   assign rshift = rscan;

   assign l_last = (scan_ff == SCAN_W'(LOCAL_ENTRIES - 1));
   assign r_last = (scan_ff == SCAN_W'(GLOBAL_ENTRIES - 1));
   assign l_hit  = lh.used && (lh.addr == mac_ff);
   assign r_hit  = rh.used && (rh.addr == mac_ff);

   assign cap   = (max_local_ff > 7'(LOCAL_ENTRIES)) ? 7'(LOCAL_ENTRIES) : max_local_ff;
   assign cnt7  = 7'(count_ff);
   assign lim   = (req_chan.read_limit > LIST_MAX) ? LIST_MAX : req_chan.read_limit;
   assign n7    = (lim < cnt7) ? lim : cnt7;

   // wrapping time: purge when now is strictly after seen + timeout
   assign age_d = now_ff - lh.seen - timeout_ff;
   assign aged  = (age_d != 32'd0) && !age_d[31];

   assign cd_load = (cd_ff != 16'd0) ? cd_ff : ((period_ff != 16'd0) ? period_ff : 16'd1);
   assign cd_next = cd_load - 16'd1;

   always_comb begin
      state_in    = state_ff;
      scan_in     = scan_ff;
      fidx_in     = fidx_ff;
      found_in    = found_ff;
      free_in     = free_ff;
      op_in       = op_ff;
      mac_in      = mac_ff;
      orig_in     = orig_ff;
      st_in       = st_ff;
      hit_orig_in = hit_orig_ff;
      n_in        = n_ff;
      emit_in     = emit_ff;
      count_in    = count_ff;
      changed_in  = changed_ff;
      now_in      = now_ff;
      cd_in       = cd_ff;
      lnew        = lh;
      rnew        = rh;
      rsp_load       = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_orig_in    = rsp_orig_ff;
      rsp_mac_in     = rsp_mac_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_last_in    = rsp_last_ff;

      if (lscan && lshift) begin
         scan_in = l_last ? '0 : scan_ff + SCAN_W'(1);
      end
      if (rscan) begin
         scan_in = r_last ? '0 : scan_ff + SCAN_W'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_chan.opcode;
               mac_in      = req_chan.mac;
               orig_in     = req_chan.orig_id;
               scan_in     = '0;
               found_in    = 1'b0;
               free_in     = 1'b0;
               hit_orig_in = 8'd0;
               st_in       = ST_DONE;
               case (req_chan.opcode)
                  OP_LEARN:    state_in = S_LFIND;
                  OP_ANNOUNCE: state_in = S_RFIND;
                  OP_LOOKUP:   state_in = S_RFIND;
                  OP_WITHDRAW: begin
                     st_in    = ST_NOT_FOUND;
                     state_in = S_RWDRAW;
                  end
                  OP_TICK: begin
                     now_in   = now_ff + 32'd1;
                     cd_in    = cd_next;
                     state_in = (cd_next == 16'd0) ? S_LPURGE : S_DONE;
                  end
                  OP_LIST: begin
                     n_in    = LCNT_W'(n7);
                     emit_in = '0;
                     if (n7 == cnt7) begin
                        changed_in = 1'b0;
                     end
                     if (n7 == 7'd0) begin
                        st_in    = ST_EMPTY;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_LLIST;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_LFIND: begin
            // a known MAC is refreshed on the way past
            if (l_hit) begin
               found_in  = 1'b1;
               lnew.seen = now_ff;
            end
            if (!lh.used && !free_ff) begin
               free_in = 1'b1;
               fidx_in = scan_ff;
            end
            if (l_last) begin
               if (found_in) begin
                  state_in = S_DONE;
               end else if (cnt7 >= cap) begin
                  st_in    = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  state_in = S_LAPPLY;
               end
            end
         end
         S_LAPPLY: begin
            if (scan_ff == fidx_ff) begin
               lnew = '{used: 1'b1, keep: (mac_ff == own_mac_ff), seen: now_ff, addr: mac_ff};
            end
            if (l_last) begin
               count_in   = count_ff + LCNT_W'(1);
               changed_in = 1'b1;
               st_in      = ST_NEW;
               state_in   = S_REVICT;
            end
         end
         S_REVICT: begin
            if (r_hit) begin
               rnew.used = 1'b0;
            end
            if (r_last) begin
               state_in = S_DONE;
            end
         end
         S_RFIND: begin
            if (r_hit) begin
               found_in = 1'b1;
               if (op_ff == OP_LOOKUP) begin
                  hit_orig_in = rh.orig;
               end else begin
                  rnew.orig = orig_ff;
               end
            end
            if (!rh.used && !free_ff) begin
               free_in = 1'b1;
               fidx_in = scan_ff;
            end
            if (r_last) begin
               if (op_ff == OP_LOOKUP) begin
                  st_in    = found_in ? ST_DONE : ST_NOT_FOUND;
                  state_in = S_DONE;
               end else if (found_in) begin
                  state_in = S_LEVICT;
               end else if (free_in) begin
                  state_in = S_RAPPLY;
               end else begin
                  st_in    = ST_FULL;
                  state_in = S_DONE;
               end
            end
         end
         S_RAPPLY: begin
            if (scan_ff == fidx_ff) begin
               rnew = '{used: 1'b1, orig: orig_ff, addr: mac_ff};
            end
            if (r_last) begin
               st_in    = ST_NEW;
               state_in = S_LEVICT;
            end
         end
         S_LEVICT, S_LPURGE: begin
            if ((state_ff == S_LEVICT) ? l_hit : (lh.used && !lh.keep && aged)) begin
               lnew.used  = 1'b0;
               changed_in = 1'b1;
               if (count_ff != '0) begin
                  count_in = count_ff - LCNT_W'(1);
               end
            end
            if (l_last) begin
               state_in = S_DONE;
            end
         end
         S_RWDRAW: begin
            if (rh.used && (rh.orig == orig_ff)) begin
               rnew.used = 1'b0;
               st_in     = ST_DONE;
            end
            if (r_last) begin
               state_in = S_DONE;
            end
         end
         S_LLIST: begin
            if (list_emit && can_emit) begin
               rsp_load       = 1'b1;
               rsp_status_in  = ST_DONE;
               rsp_orig_in    = 8'd0;
               rsp_mac_in     = lh.addr;
               rsp_changed_in = changed_ff;
               rsp_last_in    = (emit_ff == n_ff - LCNT_W'(1));
               emit_in        = emit_ff + LCNT_W'(1);
            end
            if (lshift && l_last) begin
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            if (can_emit) begin
               rsp_load       = 1'b1;
               rsp_status_in  = st_ff;
               rsp_orig_in    = hit_orig_ff;
               rsp_mac_in     = '0;
               rsp_changed_in = changed_ff;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         count_ff     <= '0;
         changed_ff   <= 1'b0;
         now_ff       <= '0;
         cd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         scan_ff    <= scan_in;
         count_ff   <= count_in;
         changed_ff <= changed_in;
         now_ff     <= now_in;
         cd_ff      <= cd_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      fidx_ff        <= fidx_in;
      found_ff       <= found_in;
      free_ff        <= free_in;
      op_ff          <= op_in;
      mac_ff         <= mac_in;
      orig_ff        <= orig_in;
      st_ff          <= st_in;
      hit_orig_ff    <= hit_orig_in;
      n_ff           <= n_in;
      emit_ff        <= emit_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_orig_ff    <= rsp_orig_in;
      rsp_mac_ff     <= rsp_mac_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.found_orig   = rsp_orig_ff;
   assign rsp_chan.entry_mac    = rsp_mac_ff;
   assign rsp_chan.changed_flag = rsp_changed_ff;
   assign rsp_chan.last         = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LCNT_W'(LOCAL_ENTRIES))
      else $error("local entry count beyond table size");

   a_tick_time: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.opcode == OP_TICK)) |=> (now_ff == $past(now_ff) + 32'd1))
      else $error("tick did not advance time by one");

   a_idle_ring_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (scan_ff == '0))
      else $error("ring not back in place when idle");

endmodule

### bench/tb_top.sv
// Self-checking bench for the MAC translation table: predictor, random traffic, CSR phases.
`timescale 1ns / 1ps
module tb_top;
   import ttu_pkg::*;

   typedef struct packed {
      logic [2:0]       opcode;
      logic [MAC_W-1:0] mac;
      logic [7:0]       orig_id;
      logic [6:0]       read_limit;
   } request_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [7:0]       found_orig;
      logic [MAC_W-1:0] entry_mac;
      logic             changed_flag;
      logic             last;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   ttu_req_if req_chan ();
   ttu_rsp_if rsp_chan ();

   mac_translation_table_unit uut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state
   logic [MAC_W-1:0] cfg_own_mac;
   logic [6:0]       cfg_max_local;
   logic [31:0]      cfg_timeout;
   logic [15:0]      cfg_period;
   logic [MAC_W-1:0] loc_addr [LOCAL_ENTRIES];
   logic [31:0]      loc_seen [LOCAL_ENTRIES];
   logic             loc_keep [LOCAL_ENTRIES];
   logic             loc_used [LOCAL_ENTRIES];
   logic [MAC_W-1:0] rem_addr [GLOBAL_ENTRIES];
   logic [7:0]       rem_orig [GLOBAL_ENTRIES];
   logic             rem_used [GLOBAL_ENTRIES];
   int               loc_count;
   logic             changed;
   logic [31:0]      now_ticks;
   logic [15:0]      countdown;

   request_type  pending_reqs [$];
   response_type expected_rsps [$];
   int           failures = 0;

   logic [MAC_W-1:0] mac_pool [16];
   bit               no_idle = 1'b0;
   bit               stim_done = 1'b0;
   int               idle_cycles = 0;
   int               accepted_reqs = 0;

   function automatic int local_slot(logic [MAC_W-1:0] m);
      for (int i = 0; i < LOCAL_ENTRIES; i++)
         if (loc_used[i] && loc_addr[i] == m) return i;
      return -1;
   endfunction

   function automatic int remote_slot(logic [MAC_W-1:0] m);
      for (int i = 0; i < GLOBAL_ENTRIES; i++)
         if (rem_used[i] && rem_addr[i] == m) return i;
      return -1;
   endfunction

   function automatic void drop_local(int i);
      loc_used[i] = 1'b0;
      if (loc_count > 0) loc_count--;
      changed = 1'b1;
   endfunction

   function automatic void push_rsp(logic [2:0] st, logic [7:0] orig,
                                    logic [MAC_W-1:0] m, logic lst);
      response_type r;
      r.status = st; r.found_orig = orig; r.entry_mac = m;
      r.changed_flag = changed; r.last = lst;
      expected_rsps.push_back(r);
   endfunction

   function automatic void reset_table();
      cfg_own_mac = '0; cfg_max_local = RST_MAX_LOCAL;
      cfg_timeout = RST_TIMEOUT; cfg_period = RST_PERIOD;
      for (int i = 0; i < LOCAL_ENTRIES; i++) loc_used[i] = 1'b0;
      for (int i = 0; i < GLOBAL_ENTRIES; i++) rem_used[i] = 1'b0;
      loc_count = 0; changed = 1'b0; now_ticks = '0; countdown = '0;
   endfunction

   function automatic void predict_table(request_type q);
      int i, g, n, cap;
      logic [2:0] st;
      logic [31:0] d;
      logic [6:0] lim;
      st = ST_DONE;
      case (q.opcode)
         OP_LEARN: begin
            cap = (cfg_max_local > LOCAL_ENTRIES) ? LOCAL_ENTRIES : cfg_max_local;
            i = local_slot(q.mac);
            if (i >= 0) begin
               loc_seen[i] = now_ticks;
            end else if (loc_count >= cap) begin
               st = ST_FULL;
            end else begin
               for (i = 0; i < LOCAL_ENTRIES; i++) if (!loc_used[i]) break;
               if (i >= LOCAL_ENTRIES) st = ST_FULL;
               else begin
                  loc_used[i] = 1'b1; loc_addr[i] = q.mac; loc_seen[i] = now_ticks;
                  loc_keep[i] = (q.mac == cfg_own_mac);
                  loc_count++; changed = 1'b1; st = ST_NEW;
                  g = remote_slot(q.mac);
                  if (g >= 0) rem_used[g] = 1'b0;
               end
            end
         end
         OP_ANNOUNCE: begin
            g = remote_slot(q.mac);
            if (g < 0) begin
               for (g = 0; g < GLOBAL_ENTRIES; g++) if (!rem_used[g]) break;
               if (g >= GLOBAL_ENTRIES) st = ST_FULL;
               else begin
                  rem_used[g] = 1'b1; rem_addr[g] = q.mac; st = ST_NEW;
               end
            end
            if (st != ST_FULL) begin
               rem_orig[g] = q.orig_id;
               i = local_slot(q.mac);
               if (i >= 0) drop_local(i);
            end
         end
         OP_WITHDRAW: begin
            st = ST_NOT_FOUND;
            for (g = 0; g < GLOBAL_ENTRIES; g++)
               if (rem_used[g] && rem_orig[g] == q.orig_id) begin
                  rem_used[g] = 1'b0; st = ST_DONE;
               end
         end
         OP_LOOKUP: begin
            g = remote_slot(q.mac);
            if (g >= 0) begin
               push_rsp(ST_DONE, rem_orig[g], '0, 1'b1);
               return;
            end
            st = ST_NOT_FOUND;
         end
         OP_TICK: begin
            now_ticks++;
            if (countdown == 0) countdown = (cfg_period != 0) ? cfg_period : 16'd1;
            countdown--;
            if (countdown == 0)
               for (i = 0; i < LOCAL_ENTRIES; i++) begin
                  if (!loc_used[i] || loc_keep[i]) continue;
                  d = now_ticks - loc_seen[i] - cfg_timeout;
                  if (d != 0 && !d[31]) drop_local(i);
               end
         end
         OP_LIST: begin
            lim = (q.read_limit > LIST_MAX) ? LIST_MAX : q.read_limit;
            n = 0;
            for (i = 0; i < LOCAL_ENTRIES && n < lim; i++) if (loc_used[i]) n++;
            if (n == loc_count) changed = 1'b0;
            if (n == 0) begin
               push_rsp(ST_EMPTY, '0, '0, 1'b1);
               return;
            end
            g = 0;
            for (i = 0; i < LOCAL_ENTRIES && g < n; i++)
               if (loc_used[i]) begin
                  push_rsp(ST_DONE, '0, loc_addr[i], g == n - 1);
                  g++;
               end
            return;
         end
         default: ;
      endcase
      push_rsp(st, '0, '0, 1'b1);
   endfunction

   // driver
   initial begin
      req_chan.valid = 1'b0; req_chan.opcode = '0; req_chan.mac = '0;
      req_chan.orig_id = '0; req_chan.read_limit = '0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_table({req_chan.opcode, req_chan.mac, req_chan.orig_id,
                           req_chan.read_limit});
            accepted_reqs++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= 10)) begin
               request_type q;
               q = pending_reqs.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.opcode <= q.opcode; req_chan.mac <= q.mac;
               req_chan.orig_id <= q.orig_id; req_chan.read_limit <= q.read_limit;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         rsp_chan.ready <= no_idle || ($urandom_range(99) >= 10);
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            response_type got, exp;
            got = {rsp_chan.status, rsp_chan.found_orig, rsp_chan.entry_mac,
                   rsp_chan.changed_flag, rsp_chan.last};
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
               failures++;
            end else begin
               exp = expected_rsps.pop_front();
               if (got.status != exp.status)
                  $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
               if (got.found_orig != exp.found_orig)
                  $display("%0t: found_orig expected %0d actual %0d", $time,
                           exp.found_orig, got.found_orig);
               if (got.entry_mac != exp.entry_mac)
                  $display("%0t: entry_mac expected %h actual %h", $time,
                           exp.entry_mac, got.entry_mac);
               if (got.changed_flag != exp.changed_flag)
                  $display("%0t: changed_flag expected %b actual %b", $time,
                           exp.changed_flag, got.changed_flag);
               if (got.last != exp.last)
                  $display("%0t: last expected %b actual %b", $time, exp.last, got.last);
               if (got != exp) failures++;
            end
         end
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready) ||
             csr_psel)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles > 20000) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [63:0] value);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(8 * idx); csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         CSR_OWN_MAC:   cfg_own_mac = value[MAC_W-1:0];
         CSR_MAX_LOCAL: cfg_max_local = value[6:0];
         CSR_TIMEOUT:   cfg_timeout = value[31:0];
         default:       cfg_period = value[15:0];
      endcase
   endtask

   task automatic drain_all();
      while (pending_reqs.size() > 0 || req_chan.valid || expected_rsps.size() > 0)
         @(posedge clock);
      // a list may still be rotating its ring after its last response
      repeat (3 * LOCAL_ENTRIES + 2 * GLOBAL_ENTRIES + 8) @(posedge clock);
   endtask

   function automatic void add_req(logic [2:0] op, logic [MAC_W-1:0] m,
                                   logic [7:0] o, logic [6:0] lim);
      request_type q;
      q.opcode = op; q.mac = m; q.orig_id = o; q.read_limit = lim;
      pending_reqs.push_back(q);
   endfunction

   function automatic void add_random(int count);
      logic [2:0] op;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(9))
            0, 1, 2: op = OP_LEARN;
            3, 4:    op = OP_ANNOUNCE;
            5:       op = OP_WITHDRAW;
            6:       op = OP_LOOKUP;
            7, 8:    op = OP_TICK;
            default: op = ($urandom_range(15) == 0) ? 3'($urandom_range(6, 7)) : OP_LIST;
         endcase
         add_req(op, ($urandom_range(3) == 0) ? MAC_W'({$urandom, $urandom}) :
                                                 mac_pool[$urandom_range(15)],
                 ($urandom_range(1)) ? 8'($urandom) : 8'($urandom_range(3)),
                 ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(8)));
      end
   endfunction

   initial begin
      reset_table();
      for (int i = 0; i < 16; i++) mac_pool[i] = MAC_W'({$urandom, $urandom});
      mac_pool[0] = '0; mac_pool[1] = '1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, every opcode, own MAC never ages, cap, list limits
      csr_write(CSR_OWN_MAC, {16'h0, mac_pool[2]});
      csr_write(CSR_PERIOD, 64'd1);
      csr_write(CSR_TIMEOUT, 64'd2);
      csr_write(CSR_MAX_LOCAL, 64'd3);
      add_req(OP_LIST, '0, '0, 7'd0);
      add_req(OP_LEARN, mac_pool[0], '0, '0);
      add_req(OP_LEARN, mac_pool[1], '0, '0);
      add_req(OP_LEARN, mac_pool[2], '0, '0);
      add_req(OP_LEARN, mac_pool[3], '0, '0);
      add_req(OP_LEARN, mac_pool[1], '0, '0);
      add_req(OP_LIST, '0, '0, 7'd1);
      add_req(OP_LIST, '0, '0, 7'h7F);
      add_req(OP_ANNOUNCE, mac_pool[1], 8'hFF, '0);
      add_req(OP_ANNOUNCE, mac_pool[1], 8'h00, '0);
      add_req(OP_ANNOUNCE, mac_pool[4], 8'h00, '0);
      add_req(OP_LOOKUP, mac_pool[1], '0, '0);
      add_req(OP_LOOKUP, mac_pool[5], '0, '0);
      add_req(OP_LEARN, mac_pool[4], '0, '0);
      add_req(OP_WITHDRAW, '0, 8'h00, '0);
      add_req(OP_WITHDRAW, '0, 8'hFF, '0);
      for (int k = 0; k < 4; k++) add_req(OP_TICK, '0, '0, '0);
      add_req(OP_LIST, '0, '0, 7'd64);
      add_req(3'd6, '1, '1, '1);
      add_req(3'd7, '0, '0, '0);
      drain_all();
      csr_write(CSR_MAX_LOCAL, 64'd0);
      add_req(OP_LEARN, mac_pool[6], '0, '0);
      drain_all();
      // random phases over several settings
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               csr_write(CSR_MAX_LOCAL, 64'd127); csr_write(CSR_TIMEOUT, 64'hFFFF_FFFF);
               csr_write(CSR_PERIOD, 64'hFFFF); csr_write(CSR_OWN_MAC, 64'hFFFF_FFFF_FFFF);
            end
            1: begin
               csr_write(CSR_MAX_LOCAL, 64'd5); csr_write(CSR_TIMEOUT, 64'd1);
               csr_write(CSR_PERIOD, 64'd2); csr_write(CSR_OWN_MAC, {16'h0, mac_pool[7]});
            end
            2: begin
               csr_write(CSR_MAX_LOCAL, 64'd64); csr_write(CSR_TIMEOUT, 64'd4);
               csr_write(CSR_PERIOD, 64'd0);
            end
            default: begin
               csr_write(CSR_MAX_LOCAL, 64'd10); csr_write(CSR_TIMEOUT, 64'd3);
               csr_write(CSR_PERIOD, 64'd3);
            end
         endcase
         no_idle = (ph == 2);
         add_random(85);
         drain_all();
      end
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

### sim.f
rtl/core/ttu_pkg.sv
rtl/core/ttu_if.sv
rtl/core/ttu_local_cell.sv
rtl/core/ttu_remote_cell.sv
rtl/core/mac_translation_table_unit.sv
bench/tb_top.sv
